// ===== rtl/core/tfrg_pkg.sv =====
// Package with the shared types, constants and the arctangent table of the rotate gesture block.
`default_nettype none
package tfrg_pkg;

	localparam int TRACKED     = 2;
	localparam int CORDIC_STEPS = 20;
	localparam int TABLE_FRAC  = 16;
	localparam int CNT_W       = 5;
	localparam int CW          = 38;
	localparam int ZW          = 28;

	localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 << TABLE_FRAC);

	typedef enum logic [1:0] {
		OP_DOWN   = 2'd0,
		OP_UP     = 2'd1,
		OP_MOVE   = 2'd2,
		OP_UPDATE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MS_LXNX = 2'd0,
		MS_LYNY = 2'd1,
		MS_LXNY = 2'd2,
		MS_LYNX = 2'd3
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPLY,
		ST_DIFF,
		ST_MUL,
		ST_MACC,
		ST_PREP,
		ST_CORDIC,
		ST_ROUND,
		ST_ACC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             apply;
		logic             diff;
		logic             reject;
		logic             mul_en;
		mul_sel_t         mul_sel;
		logic             prep;
		logic             step_en;
		logic [CNT_W-1:0] step;
		logic             round;
		logic             accum;
		logic             emit;
	} cmd_t;

	typedef struct packed {
		logic is_move;
		logic basis;
		logic nonzero;
		logic out_free;
	} sts_t;

	// Arctangent of 2^-i in units of 2^-16 degree.
	function automatic logic [21:0] tfrg_atan(input logic [CNT_W-1:0] i);
		logic [21:0] r;
		case (i)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/two_finger_rotate_gesture.sv =====
// Top level of the two-finger rotation gesture detector.
`default_nettype none
// Each touch item may update the two tracked pointer slots and yields one result
// item carrying the accepted flag, a rotate flag, the doubled centre and the
// running rotation total in 2^-ANGLE_FRAC_BITS degree units. One item is
// processed at a time. Items other than a live move (down, up, update, a bad slot
// or any item after the gesture has ended) go from the slot update straight to the
// result; a move without a rotation basis or with a zero finger-to-finger vector
// ends before the multiplier. A move that issues a rotation makes four passes
// through the shared 17x17 multiplier that form the dot and cross products and
// then runs the 20 iterations of the CORDIC arctangent unit. A finished result
// waits while the output register holds a stalled result.
// The output register holds a finished result while the next item is accepted.
module two_finger_rotate_gesture #(
	parameter int SLOT_COUNT      = 2,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         operation,
	input  wire logic [3:0]         slot_index,
	input  wire logic               point_valid,
	input  wire logic               point_moving,
	input  wire logic signed [15:0] prev_x,
	input  wire logic signed [15:0] prev_y,
	input  wire logic signed [15:0] now_x,
	input  wire logic signed [15:0] now_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    accepted,
	output logic                    rotate_event,
	output logic signed [16:0]      centre_x_twice,
	output logic signed [16:0]      centre_y_twice,
	output logic signed [31:0]      total_angle
);
	import tfrg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tfrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tfrg_dp #(
		.SLOT_COUNT      (SLOT_COUNT),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.slot_index     (slot_index),
		.point_valid    (point_valid),
		.point_moving   (point_moving),
		.prev_x         (prev_x),
		.prev_y         (prev_y),
		.now_x          (now_x),
		.now_y          (now_y),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.accepted       (accepted),
		.rotate_event   (rotate_event),
		.centre_x_twice (centre_x_twice),
		.centre_y_twice (centre_y_twice),
		.total_angle    (total_angle)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in progress");

	a_rotate_implies_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rotate_event) |-> accepted)
		else $error("rotate event on a rejected item");

	a_no_rotate_zero_centre: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rotate_event) |-> (centre_x_twice == '0 && centre_y_twice == '0))
		else $error("centre reported without a rotate event");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tfrg_ctrl.sv =====
// Controller state machine that sequences the rotate gesture datapath.
`default_nettype none
module tfrg_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire tfrg_pkg::sts_t sts,
	output tfrg_pkg::cmd_t      cmd
);
	import tfrg_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		cmd.mul_sel = MS_LXNX;
		cmd.step    = cnt_q;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = sts.is_move ? ST_DIFF : ST_EMIT;
			end
			ST_DIFF: begin
				cnt_d = '0;
				if (!sts.basis) begin
					cmd.reject = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					cmd.diff = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == '0 && !sts.nonzero) begin
					state_d = ST_EMIT;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = mul_sel_t'(cnt_q[1:0]);
					if (cnt_q == CNT_W'(3)) begin
						cnt_d   = '0;
						state_d = ST_MACC;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			ST_MACC: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = ST_CORDIC;
			end
			ST_CORDIC: begin
				cmd.step_en = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_ROUND;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_ACC;
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/tfrg_dp.sv =====
// Datapath with the slot store, shared multiplier, CORDIC unit, angle total and output register.
`default_nettype none
module tfrg_dp #(
	parameter int SLOT_COUNT      = 2,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tfrg_pkg::cmd_t     cmd,
	output tfrg_pkg::sts_t          sts,
	input  wire logic [1:0]         operation,
	input  wire logic [3:0]         slot_index,
	input  wire logic               point_valid,
	input  wire logic               point_moving,
	input  wire logic signed [15:0] prev_x,
	input  wire logic signed [15:0] prev_y,
	input  wire logic signed [15:0] now_x,
	input  wire logic signed [15:0] now_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    accepted,
	output logic                    rotate_event,
	output logic signed [16:0]      centre_x_twice,
	output logic signed [16:0]      centre_y_twice,
	output logic signed [31:0]      total_angle
);
	import tfrg_pkg::*;

	localparam int RSH = TABLE_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] RND = ZW'(1 << (RSH - 1));

	op_t                op_q;
	logic [3:0]         idx_q;
	logic               pv_q, pm_q;
	logic signed [15:0] ipx_q, ipy_q, inx_q, iny_q;

	logic [TRACKED-1:0] sv_q, sm_q;
	logic signed [15:0] spx_q [TRACKED];
	logic signed [15:0] spy_q [TRACKED];
	logic signed [15:0] snx_q [TRACKED];
	logic signed [15:0] sny_q [TRACKED];
	logic               done_q;
	logic signed [31:0] sum_q;

	logic signed [16:0] lx_q, ly_q, nx_q, ny_q;
	logic signed [16:0] ma, mb;
	logic signed [33:0] prod_s1;
	logic               acc_s1;
	mul_sel_t           sel_s1;
	logic signed [34:0] dot_q, cross_q;

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, at, ang_q;
	logic signed [32:0]   sum_wide;
	logic signed [31:0]   sum_sat;

	logic               res_acc_q, res_rot_q;
	logic signed [16:0] res_cx_q, res_cy_q;
	logic               out_valid_q;

	logic good, live, nv0, nv1;

	assign good = idx_q < 4'(SLOT_COUNT);
	assign live = good && !done_q;
	assign nv0  = (idx_q == 4'd0) ? sv_q[1] : sv_q[0];
	assign nv1  = (idx_q <= 4'd1) ? 1'b0 : sv_q[1];

	assign sts.is_move  = live && op_q == OP_MOVE;
	assign sts.basis    = sv_q[0] && sv_q[1] && (sm_q[0] || sm_q[1]);
	assign sts.nonzero  = (lx_q != '0 || ly_q != '0) && (nx_q != '0 || ny_q != '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(operation);
			idx_q <= slot_index;
			pv_q  <= point_valid;
			pm_q  <= point_moving;
			ipx_q <= prev_x;
			ipy_q <= prev_y;
			inx_q <= now_x;
			iny_q <= now_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q   <= '0;
			sm_q   <= '0;
			done_q <= 1'b0;
			sum_q  <= '0;
			for (int i = 0; i < TRACKED; i++) begin
				spx_q[i] <= '0;
				spy_q[i] <= '0;
				snx_q[i] <= '0;
				sny_q[i] <= '0;
			end
		end else begin
			if (cmd.apply && live) begin
				if (op_q == OP_UP) begin
					if (idx_q == 4'd0) begin
						sv_q[0]  <= sv_q[1];
						sm_q[0]  <= sm_q[1];
						spx_q[0] <= spx_q[1];
						spy_q[0] <= spy_q[1];
						snx_q[0] <= snx_q[1];
						sny_q[0] <= sny_q[1];
					end
					if (idx_q <= 4'd1) begin
						sv_q[1]  <= 1'b0;
						sm_q[1]  <= 1'b0;
						spx_q[1] <= '0;
						spy_q[1] <= '0;
						snx_q[1] <= '0;
						sny_q[1] <= '0;
					end
					done_q <= !nv0 && !nv1;
				end else begin
					for (int i = 0; i < TRACKED; i++) begin
						if (idx_q == 4'(i)) begin
							sv_q[i]  <= pv_q;
							sm_q[i]  <= pm_q;
							spx_q[i] <= ipx_q;
							spy_q[i] <= ipy_q;
							snx_q[i] <= inx_q;
							sny_q[i] <= iny_q;
						end
					end
					if (op_q == OP_DOWN) begin
						sum_q <= '0;
					end
				end
			end
			if (cmd.accum) begin
				sum_q <= sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			lx_q <= 17'(spx_q[0]) - 17'(spx_q[1]);
			ly_q <= 17'(spy_q[0]) - 17'(spy_q[1]);
			nx_q <= 17'(snx_q[0]) - 17'(snx_q[1]);
			ny_q <= 17'(sny_q[0]) - 17'(sny_q[1]);
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			MS_LXNX: begin ma = lx_q; mb = nx_q; end
			MS_LYNY: begin ma = ly_q; mb = ny_q; end
			MS_LXNY: begin ma = lx_q; mb = ny_q; end
			MS_LYNX: begin ma = ly_q; mb = nx_q; end
			default: begin ma = lx_q; mb = nx_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
		end else begin
			acc_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= ma * mb;
			sel_s1  <= cmd.mul_sel;
		end
		if (acc_s1) begin
			case (sel_s1)
				MS_LXNX: dot_q   <= 35'(prod_s1);
				MS_LYNY: dot_q   <= dot_q + 35'(prod_s1);
				MS_LXNY: cross_q <= 35'(prod_s1);
				MS_LYNX: cross_q <= cross_q - 35'(prod_s1);
				default: dot_q   <= dot_q;
			endcase
		end
	end

	assign xs = x_q >>> cmd.step;
	assign ys = y_q >>> cmd.step;
	assign at = signed'(ZW'(tfrg_atan(cmd.step)));

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			if (dot_q[34]) begin
				x_q <= -CW'(dot_q);
				y_q <= -CW'(cross_q);
				z_q <= cross_q[34] ? -Z_HALF_TURN : Z_HALF_TURN;
			end else begin
				x_q <= CW'(dot_q);
				y_q <= CW'(cross_q);
				z_q <= '0;
			end
		end else if (cmd.step_en) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		if (cmd.round) begin
			ang_q <= (z_q + RND) >>> RSH;
		end
	end

	assign sum_wide = 33'(sum_q) + 33'(ang_q);
	assign sum_sat  = (sum_wide[32] != sum_wide[31])
		? (sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum_wide[31:0];

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			res_acc_q <= good;
			res_rot_q <= 1'b0;
			res_cx_q  <= '0;
			res_cy_q  <= '0;
		end
		if (cmd.reject) begin
			res_acc_q <= 1'b0;
		end
		if (cmd.accum) begin
			res_rot_q <= 1'b1;
			res_cx_q  <= 17'(snx_q[0]) + 17'(snx_q[1]);
			res_cy_q  <= 17'(sny_q[0]) + 17'(sny_q[1]);
		end
		if (cmd.emit) begin
			accepted       <= res_acc_q;
			rotate_event   <= res_rot_q;
			centre_x_twice <= res_cx_q;
			centre_y_twice <= res_cy_q;
			total_angle    <= sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
